/* sv/sbt_pkg.sv */
// Types, constants and character helpers shared by the source byte tokenizer.
package sbt_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_USC   = 8'h5F;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [6:0] K_IDENT    = 7'd37;
	localparam logic [6:0] K_INT_BASE = 7'd38;
	localparam logic [6:0] K_EOF      = 7'd42;
	localparam logic [6:0] K_CHARLIT  = 7'd88;
	localparam logic [6:0] K_STRING   = 7'd89;
	localparam logic [6:0] K_FLOAT    = 7'd90;
	localparam logic [6:0] K_ERROR    = 7'd91;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_BADCHAR  = 3'd1;
	localparam logic [2:0] E_UNTERM   = 3'd2;
	localparam logic [2:0] E_BASE     = 3'd3;
	localparam logic [2:0] E_NDFLOAT  = 3'd4;
	localparam logic [2:0] E_UNEXP    = 3'd5;

	localparam int NKW = 37;
	localparam int KW_CMP = 9;

	localparam logic [71:0] KW_STR [NKW] = '{
		"void", "volatile", "var", "namespace", "null", "class", "case", "const",
		"continue", "char", "enum", "else", "return", "this", "true", "while",
		"for", "float", "false", "if", "inline", "switch", "sint8", "sint16",
		"sint32", "sint64", "default", "double", "break", "breakall", "breakto",
		"bool", "assert", "uint8", "uint16", "uint32", "uint64"
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd4, 4'd8, 4'd3, 4'd9, 4'd4, 4'd5, 4'd4, 4'd5, 4'd8, 4'd4, 4'd4, 4'd4,
		4'd6, 4'd4, 4'd4, 4'd5, 4'd3, 4'd5, 4'd5, 4'd2, 4'd6, 4'd6, 4'd5, 4'd6,
		4'd6, 4'd6, 4'd7, 4'd6, 4'd5, 4'd8, 4'd7, 4'd4, 4'd6, 4'd5, 4'd6, 4'd6,
		4'd6
	};

	typedef struct packed {
		logic digit;
		logic alpha;
		logic oct;
		logic bin;
		logic hex;
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		cls_t       cls;
	} ent_t;

	typedef struct packed {
		logic [6:0]  kind;
		logic [2:0]  err;
		logic [31:0] offset;
		logic [15:0] len;
		logic [15:0] line;
		logic [15:0] col;
	} tok_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] single;
		logic       eqv;
		logic [6:0] eq;
		logic       dblv;
		logic [6:0] dbl;
		logic       dbleqv;
		logic [6:0] dbleq;
	} op_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] kind;
	} punct_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r.digit = (c >= 8'h30) && (c <= 8'h39);
		r.alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			(c == CH_USC);
		r.oct = (c >= 8'h30) && (c <= 8'h37);
		r.bin = (c == 8'h30) || (c == 8'h31);
		r.hex = r.digit || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
		return r;
	endfunction

	function automatic logic in_base(input cls_t c, input logic [1:0] base);
		logic r;
		case (base)
			2'd0: r = c.digit;
			2'd1: r = c.oct;
			2'd2: r = c.bin;
			default: r = c.hex;
		endcase
		return r;
	endfunction

	function automatic op_t op_lookup(input logic [7:0] c);
		op_t r;
		r = '0;
		r.hit = 1'b1;
		case (c)
			8'h3D: begin r.single = 7'd55; r.dblv = 1'b1; r.dbl = 7'd54; end
			8'h3A: begin r.single = 7'd57; r.dblv = 1'b1; r.dbl = 7'd56; end
			8'h2A: begin r.single = 7'd59; r.eqv = 1'b1; r.eq = 7'd58; end
			8'h2F: begin r.single = 7'd61; r.eqv = 1'b1; r.eq = 7'd60; end
			8'h21: begin r.single = 7'd63; r.eqv = 1'b1; r.eq = 7'd62; end
			8'h25: begin r.single = 7'd65; r.eqv = 1'b1; r.eq = 7'd64; end
			8'h5E: begin r.single = 7'd67; r.eqv = 1'b1; r.eq = 7'd66; end
			8'h2B: begin
				r.single = 7'd70; r.eqv = 1'b1; r.eq = 7'd69; r.dblv = 1'b1; r.dbl = 7'd68;
			end
			8'h2D: begin
				r.single = 7'd73; r.eqv = 1'b1; r.eq = 7'd72; r.dblv = 1'b1; r.dbl = 7'd71;
			end
			8'h26: begin
				r.single = 7'd76; r.eqv = 1'b1; r.eq = 7'd75; r.dblv = 1'b1; r.dbl = 7'd74;
			end
			8'h7C: begin
				r.single = 7'd79; r.eqv = 1'b1; r.eq = 7'd78; r.dblv = 1'b1; r.dbl = 7'd77;
			end
			8'h3E: begin
				r.single = 7'd83; r.eqv = 1'b1; r.eq = 7'd82; r.dblv = 1'b1; r.dbl = 7'd81;
				r.dbleqv = 1'b1; r.dbleq = 7'd80;
			end
			8'h3C: begin
				r.single = 7'd87; r.eqv = 1'b1; r.eq = 7'd86; r.dblv = 1'b1; r.dbl = 7'd85;
				r.dbleqv = 1'b1; r.dbleq = 7'd84;
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic punct_t punct_lookup(input logic [7:0] c);
		punct_t r;
		r.hit = 1'b1;
		case (c)
			8'h28: r.kind = 7'd43;
			8'h29: r.kind = 7'd44;
			8'h5B: r.kind = 7'd45;
			8'h5D: r.kind = 7'd46;
			8'h7B: r.kind = 7'd47;
			8'h7D: r.kind = 7'd48;
			8'h2C: r.kind = 7'd49;
			8'h2E: r.kind = 7'd50;
			8'h3B: r.kind = 7'd51;
			8'h3F: r.kind = 7'd52;
			8'h7E: r.kind = 7'd53;
			default: begin r.hit = 1'b0; r.kind = 7'd0; end
		endcase
		return r;
	endfunction

	// first matching keyword wins; len 0 never matches
	function automatic logic [6:0] kw_kind(input logic [KW_CMP-1:0][7:0] pre,
		input logic [3:0] len);
		logic       hit;
		logic [6:0] k;
		int         b;
		k = K_IDENT;
		for (int i = NKW - 1; i >= 0; i--) begin
			hit = (KW_LEN[i] == len);
			for (int j = 0; j < KW_CMP; j++) begin
				if (j < int'(len)) begin
					b = 8 * (int'(len) - 1 - j);
					if (pre[j] != KW_STR[i][b +: 8])
						hit = 1'b0;
				end
			end
			if (hit)
				k = 7'(i);
		end
		return k;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] x);
		return (x == 16'hFFFF) ? x : x + 16'd1;
	endfunction

endpackage

/* sv/sbt_front.sv */
// Input side: takes source bytes, classifies them and queues them for the lexer.
module sbt_front import sbt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] src_byte,
	input  logic       src_last,
	output logic       q_valid,
	output ent_t       q_ent,
	input  logic       q_pop
);

	ent_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;
	logic               push;
	ent_t               ent_in;

	assign src_stall = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign push      = src_valid && !src_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_ent     = mem_q[rd_q];

	always_comb begin
		ent_in.ch   = src_byte;
		ent_in.last = src_last;
		ent_in.cls  = classify(src_byte);
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= ent_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (q_pop)
				rd_q <= rd_q + 1'b1;
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/sbt_back.sv */
// Lexer core: one window step per cycle unless stalled; registers tokens.
module sbt_back import sbt_pkg::*; #(
	parameter int KEYWORD_MAX_LEN = 9,
	parameter int OFFSET_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  ent_t q_ent,
	output logic q_pop,
	output logic tok_valid,
	input  logic tok_stall,
	output tok_t tok,
	output logic tok_last
);

	localparam int IW = $clog2(KEYWORD_MAX_LEN);
	localparam int OB = OFFSET_BITS;

	localparam logic [3:0] M_IDLE       = 4'd0;
	localparam logic [3:0] M_LINECOM    = 4'd1;
	localparam logic [3:0] M_BLOCK      = 4'd2;
	localparam logic [3:0] M_BLOCK_STAR = 4'd3;
	localparam logic [3:0] M_OP1        = 4'd4;
	localparam logic [3:0] M_OP2        = 4'd5;
	localparam logic [3:0] M_CPREFIX    = 4'd6;
	localparam logic [3:0] M_CHAR_BODY  = 4'd7;
	localparam logic [3:0] M_CHAR_CLOSE = 4'd8;
	localparam logic [3:0] M_STRING     = 4'd9;
	localparam logic [3:0] M_ZERO       = 4'd10;
	localparam logic [3:0] M_DIGITS     = 4'd11;
	localparam logic [3:0] M_FRAC       = 4'd12;
	localparam logic [3:0] M_IDENT      = 4'd13;

	logic [3:0]                      mode_q;
	ent_t                            w0_q, w1_q;
	logic [1:0]                      wn_q;
	logic                            fin_q, act_q;
	logic [2:0]                      cnt_q;
	logic [7:0]                      quote_q;
	logic [1:0]                      base_q;
	logic [KEYWORD_MAX_LEN-1:0][7:0] kw_q;
	logic [OB-1:0]                   off_q, tbeg_q;
	logic [15:0]                     line_q, col_q, tline_q, tcol_q;
	logic                            p_vld_q, p_known_q;
	tok_t                            p_tok_q;
	logic                            o_vld_q, o_last_q;
	tok_t                            o_tok_q;

	logic        have0, have1, end0, wait1;
	logic [7:0]  c0, c1;
	cls_t        cls0, cls1;
	op_t         opq, opc;
	punct_t      pk;
	logic        wait_end, fin_end, nl, st, em, set_q, set_b, kw_we, kw_at0, do_begin;
	logic [1:0]  tk, nb, wn_after, wn_base;
	logic [3:0]  nmode;
	logic [6:0]  ekind;
	logic [2:0]  eerr;
	logic [OB-1:0] diff, off1, eff_tbeg, len;
	logic [15:0] line1, col1, eff_tl, eff_tc;
	logic [63:0] len_ext, tbeg_ext;
	logic [3:0]  kwlen;
	tok_t        new_tok;
	logic        kept, blocked, go, step_end, load, o_free, emit_now, mark_last, p_move;
	logic [IW-1:0] kw_idx;

	assign have0 = (wn_q != 2'd0);
	assign have1 = (wn_q == 2'd2);
	assign c0    = have0 ? w0_q.ch : 8'h00;
	assign c1    = have1 ? w1_q.ch : 8'h00;
	assign cls0  = have0 ? w0_q.cls : '0;
	assign cls1  = have1 ? w1_q.cls : '0;
	assign end0  = !have0 && fin_q;
	assign wait1 = !have1 && !fin_q;
	assign opq   = op_lookup(quote_q);
	assign opc   = op_lookup(c0);
	assign pk    = punct_lookup(c0);
	assign diff  = off_q - tbeg_q;
	assign kwlen = (diff > OB'(KW_CMP)) ? 4'd0 : diff[3:0];

	always_comb begin
		wait_end = 1'b0;
		fin_end  = 1'b0;
		tk       = 2'd0;
		nl       = 1'b0;
		st       = 1'b0;
		em       = 1'b0;
		ekind    = K_ERROR;
		eerr     = E_NONE;
		nmode    = mode_q;
		set_q    = 1'b0;
		set_b    = 1'b0;
		nb       = base_q;
		kw_we    = 1'b0;
		kw_at0   = 1'b0;
		do_begin = 1'b0;
		if (!have0 && !fin_q) begin
			wait_end = 1'b1;
		end else begin
			case (mode_q)
				M_IDLE: begin
					if (end0) begin
						st = 1'b1; em = 1'b1; ekind = K_EOF; fin_end = 1'b1;
					end else if (c0 == CH_SP || c0 == CH_TAB || c0 == CH_CR) begin
						tk = 2'd1;
					end else if (c0 == CH_NL) begin
						tk = 2'd1; nl = 1'b1;
					end else if (c0 == CH_SLASH) begin
						if (wait1)
							wait_end = 1'b1;
						else if (c1 == CH_SLASH) begin
							tk = 2'd2; nmode = M_LINECOM;
						end else if (c1 == CH_STAR) begin
							tk = 2'd2; nmode = M_BLOCK_STAR;
						end else
							do_begin = 1'b1;
					end else
						do_begin = 1'b1;
				end
				M_LINECOM: begin
					if (end0 || c0 == CH_NL)
						nmode = M_IDLE;
					else
						tk = 2'd1;
				end
				M_BLOCK, M_BLOCK_STAR: begin
					if (end0)
						nmode = M_IDLE;
					else if (mode_q == M_BLOCK_STAR && c0 == CH_SLASH) begin
						tk = 2'd1; nmode = M_IDLE;
					end else begin
						tk = 2'd1;
						nl = (c0 == CH_NL);
						nmode = (c0 == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
					end
				end
				M_OP1: begin
					if (!opq.hit) begin
						em = 1'b1; eerr = E_UNEXP;
					end else if (opq.dblv && c0 == quote_q) begin
						tk = 2'd1;
						if (opq.dbleqv)
							nmode = M_OP2;
						else begin
							em = 1'b1; ekind = opq.dbl;
						end
					end else if (opq.eqv && c0 == CH_EQ) begin
						tk = 2'd1; em = 1'b1; ekind = opq.eq;
					end else begin
						em = 1'b1; ekind = opq.single;
					end
				end
				M_OP2: begin
					if (!opq.hit) begin
						em = 1'b1; eerr = E_UNEXP;
					end else if (c0 == CH_EQ) begin
						tk = 2'd1; em = 1'b1; ekind = opq.dbleq;
					end else begin
						em = 1'b1; ekind = opq.dbl;
					end
				end
				M_CPREFIX: begin
					if (c0 == CH_SQ || c0 == CH_DQ) begin
						tk = 2'd1; set_q = 1'b1; nmode = M_CHAR_BODY;
					end else
						nmode = M_IDENT;
				end
				M_CHAR_BODY: begin
					if (end0) begin
						em = 1'b1; eerr = E_BADCHAR;
					end else begin
						tk = 2'd1; nmode = M_CHAR_CLOSE;
					end
				end
				M_CHAR_CLOSE: begin
					if (c0 == quote_q) begin
						tk = 2'd1; em = 1'b1; ekind = K_CHARLIT;
					end else begin
						em = 1'b1; eerr = E_BADCHAR;
					end
				end
				M_STRING: begin
					if (c0 == quote_q) begin
						tk = 2'd1; em = 1'b1; ekind = K_STRING;
					end else if (end0 || c0 == CH_NL) begin
						em = 1'b1; eerr = E_UNTERM;
					end else
						tk = 2'd1;
				end
				M_ZERO: begin
					if (cls0.digit || !cls0.alpha) begin
						set_b = 1'b1; nb = 2'd0; nmode = M_DIGITS;
					end else if (c0 == CH_O) begin
						set_b = 1'b1; nb = 2'd1; tk = 2'd1; nmode = M_DIGITS;
					end else if (c0 == CH_B) begin
						set_b = 1'b1; nb = 2'd2; tk = 2'd1; nmode = M_DIGITS;
					end else if (c0 == CH_X) begin
						set_b = 1'b1; nb = 2'd3; tk = 2'd1; nmode = M_DIGITS;
					end else begin
						em = 1'b1; eerr = E_BASE;
					end
				end
				M_DIGITS: begin
					if (in_base(cls0, base_q))
						tk = 2'd1;
					else if (c0 == CH_DOT) begin
						if (wait1)
							wait_end = 1'b1;
						else if (in_base(cls1, base_q)) begin
							tk = 2'd1; nmode = M_FRAC;
						end else begin
							em = 1'b1; ekind = K_INT_BASE + 7'(base_q);
						end
					end else begin
						em = 1'b1; ekind = K_INT_BASE + 7'(base_q);
					end
				end
				M_FRAC: begin
					if (in_base(cls0, base_q))
						tk = 2'd1;
					else if (base_q == 2'd0) begin
						em = 1'b1; ekind = K_FLOAT;
					end else begin
						em = 1'b1; eerr = E_NDFLOAT;
					end
				end
				M_IDENT: begin
					if (cls0.alpha || cls0.digit) begin
						kw_we = 1'b1; tk = 2'd1;
					end else begin
						em = 1'b1; ekind = kw_kind(kw_q[KW_CMP-1:0], kwlen);
					end
				end
				default: nmode = M_IDLE;
			endcase
			if (do_begin) begin
				st = 1'b1;
				tk = 2'd1;
				if (pk.hit) begin
					em = 1'b1; ekind = pk.kind;
				end else if (opc.hit) begin
					set_q = 1'b1; nmode = M_OP1;
				end else if (c0 == CH_C) begin
					kw_we = 1'b1; kw_at0 = 1'b1; nmode = M_CPREFIX;
				end else if (c0 == CH_SQ || c0 == CH_DQ) begin
					set_q = 1'b1; nmode = M_STRING;
				end else if (c0 == CH_ZERO) begin
					nmode = M_ZERO;
				end else if (cls0.digit) begin
					set_b = 1'b1; nb = 2'd0; nmode = M_DIGITS;
				end else if (cls0.alpha) begin
					kw_we = 1'b1; kw_at0 = 1'b1; nmode = M_IDENT;
				end else begin
					em = 1'b1; eerr = E_UNEXP;
				end
			end
			if (em)
				nmode = M_IDLE;
		end
	end

	always_comb begin
		off1  = off_q + OB'(tk);
		line1 = line_q;
		col1  = col_q;
		if (tk == 2'd1) begin
			if (nl) begin
				line1 = sat_inc(line_q);
				col1  = 16'd1;
			end else
				col1 = sat_inc(col_q);
		end else if (tk == 2'd2)
			col1 = sat_inc(sat_inc(col_q));
		eff_tbeg = st ? off_q : tbeg_q;
		eff_tl   = st ? line_q : tline_q;
		eff_tc   = st ? col_q : tcol_q;
		len      = off1 - eff_tbeg;
		len_ext  = 64'(len);
		tbeg_ext = 64'(eff_tbeg);
		new_tok.kind   = ekind;
		new_tok.err    = eerr;
		new_tok.offset = tbeg_ext[31:0];
		new_tok.len    = (len_ext > 64'd65535) ? 16'hFFFF : len_ext[15:0];
		new_tok.line   = eff_tl;
		new_tok.col    = eff_tc;
		kw_idx = kw_at0 ? '0 : diff[IW-1:0];
	end

	assign o_free    = !o_vld_q || !tok_stall;
	assign kept      = em && (cnt_q < 3'd4);
	assign blocked   = kept && p_vld_q && !o_free;
	assign go        = act_q && !blocked;
	assign wn_after  = wn_q - tk;
	assign step_end  = wait_end || fin_end || (wn_after == 2'd0 && !fin_q);
	assign load      = q_valid && (!act_q || (go && step_end));
	assign q_pop     = load;
	assign emit_now  = go && kept;
	assign mark_last = go && step_end;
	assign p_move    = p_vld_q && o_free && (p_known_q || emit_now);
	assign wn_base   = (act_q && go) ? wn_after : wn_q;

	assign tok_valid = o_vld_q;
	assign tok       = o_tok_q;
	assign tok_last  = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			w0_q    <= '0;
			w1_q    <= '0;
			wn_q    <= 2'd0;
			fin_q   <= 1'b0;
			act_q   <= 1'b0;
			cnt_q   <= 3'd0;
			quote_q <= 8'd0;
			base_q  <= 2'd0;
			kw_q    <= '0;
			off_q   <= '0;
			tbeg_q  <= '0;
			line_q  <= 16'd1;
			col_q   <= 16'd1;
			tline_q <= 16'd1;
			tcol_q  <= 16'd1;
		end else begin
			if (go) begin
				if (fin_end) begin
					mode_q  <= M_IDLE;
					quote_q <= 8'd0;
					base_q  <= 2'd0;
					kw_q    <= '0;
					off_q   <= '0;
					tbeg_q  <= '0;
					line_q  <= 16'd1;
					col_q   <= 16'd1;
					tline_q <= 16'd1;
					tcol_q  <= 16'd1;
				end else begin
					mode_q <= nmode;
					off_q  <= off1;
					line_q <= line1;
					col_q  <= col1;
					if (st) begin
						tbeg_q  <= off_q;
						tline_q <= line_q;
						tcol_q  <= col_q;
					end
					if (set_q)
						quote_q <= c0;
					if (set_b)
						base_q <= nb;
					if (kw_we && (kw_at0 || diff < OB'(KEYWORD_MAX_LEN)))
						kw_q[kw_idx] <= c0;
				end
			end
			if (load && wn_base == 2'd0)
				w0_q <= q_ent;
			else if (go && tk == 2'd1)
				w0_q <= w1_q;
			if (load && wn_base != 2'd0)
				w1_q <= q_ent;
			if (load)
				cnt_q <= 3'd0;
			else if (go && kept)
				cnt_q <= cnt_q + 3'd1;
			if (load) begin
				wn_q  <= wn_base + 2'd1;
				fin_q <= q_ent.last;
				act_q <= 1'b1;
			end else begin
				wn_q <= wn_base;
				if (go && step_end)
					act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_vld_q   <= 1'b0;
			p_known_q <= 1'b0;
			o_vld_q   <= 1'b0;
			o_last_q  <= 1'b0;
		end else begin
			if (p_move) begin
				o_vld_q  <= 1'b1;
				o_last_q <= p_known_q;
			end else if (o_vld_q && !tok_stall)
				o_vld_q <= 1'b0;
			if (emit_now) begin
				p_vld_q   <= 1'b1;
				p_known_q <= mark_last;
			end else if (p_move)
				p_vld_q <= 1'b0;
			else if (mark_last && p_vld_q)
				p_known_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (p_move)
			o_tok_q <= p_tok_q;
		if (emit_now)
			p_tok_q <= new_tok;
	end

endmodule

/* sv/source_byte_tokenizer.sv */
// Top level of the source byte tokenizer: byte queue, lexer core, token ports.
//
//  channel | direction | handshake            | payload
//  src     | in        | src_valid/src_stall  | src_byte, src_last
//  tok     | out       | tok_valid/tok_stall  | token_kind .. column_number, run_last
//
// One lexer step per cycle unless a byte is awaited or the output holds the core. A
// step consumes bytes, closes a token, or changes mode to look at the byte again; a
// slash or dot waits for its next byte, and the final byte also brings an EOF token.
// A four-beat byte queue decouples input from the lexer; tokens leave through a
// pending register and an output register, so a stalled output holds the core.
// Reset (arst_n low) clears positions to line 1, column 1, offset 0.
module source_byte_tokenizer import sbt_pkg::*; #(
	parameter int KEYWORD_MAX_LEN = 9,
	parameter int OFFSET_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  src_byte,
	input  logic        src_last,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [6:0]  token_kind,
	output logic [2:0]  error_kind,
	output logic [31:0] start_offset,
	output logic [15:0] token_length,
	output logic [15:0] line_number,
	output logic [15:0] column_number,
	output logic        run_last
);

	logic q_valid, q_pop;
	ent_t q_ent;
	tok_t tok;

	sbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_byte  (src_byte),
		.src_last  (src_last),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop)
	);

	sbt_back #(
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
		.OFFSET_BITS     (OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.tok_last  (run_last)
	);

	assign token_kind    = tok.kind;
	assign error_kind    = tok.err;
	assign start_offset  = tok.offset;
	assign token_length  = tok.len;
	assign line_number   = tok.line;
	assign column_number = tok.col;

endmodule

/* verif/tb_source_byte_tokenizer.sv */
// Self-checking testbench for the source byte tokenizer: predicted tokens vs. token port.
module tb_source_byte_tokenizer;
	import sbt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOOK_END = -1;
	localparam int LOOK_WAIT = -2;
	localparam int PREFIX_MAX = 9;
	localparam logic [6:0] K_PUNCT_BASE = 7'd43;
	localparam logic [6:0] K_OP_BASE = 7'd54;
	localparam string PUNCT_CHARS = "()[]{},.;?~";
	localparam string OP_CHARS = "=:*/!%^+-&|><";
	localparam string NUM_CHARS = "0123456789abcdefG";
	localparam string FRAC_CHARS = "0123478fx";
	localparam string CMT_CHARS = "ab*/\n ";
	localparam string BLANK_CHARS = "\t\n \015";
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRESSURE_CYCLES = 400;

	typedef enum logic [3:0] {
		LX_IDLE, LX_LINECOM, LX_BLOCK, LX_BLOCK_STAR, LX_OP1, LX_OP2, LX_CPREFIX,
		LX_CHAR_BODY, LX_CHAR_CLOSE, LX_STRING, LX_ZERO, LX_DIGITS, LX_FRAC, LX_IDENT
	} lex_state_e;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} src_beat_t;

	typedef struct {
		tok_t t;
		logic last;
	} tok_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  src_byte = 8'd0;
	logic        src_last = 1'b0;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [6:0]  token_kind;
	logic [2:0]  error_kind;
	logic [31:0] start_offset;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic        run_last;

	source_byte_tokenizer i_dut (.*);

	initial forever #10 clk = ~clk;

	src_beat_t byte_pend[$];
	tok_beat_t tok_expect[$];
	int        err_count = 0;
	int        bytes_in = 0;
	bit        quiet = 1'b0;
	bit        in_fire, out_fire;

	// lexer shadow state
	lex_state_e  lx;
	logic [7:0]  held[$];
	logic [7:0]  quote;
	logic [1:0]  nbase;
	logic [7:0]  kwp [PREFIX_MAX];
	logic [31:0] off, tbeg;
	logic [15:0] cline, ccol, tline, tcol;
	logic [7:0]  sbuf [3];
	int          sn, spos;
	bit          sfin;
	tok_t        step_toks[$];

	function automatic void lex_reset();
		lx = LX_IDLE;
		held.delete();
		quote = '0;
		nbase = '0;
		foreach (kwp[i]) kwp[i] = '0;
		off = '0;
		tbeg = '0;
		cline = 16'd1;
		ccol = 16'd1;
		tline = 16'd1;
		tcol = 16'd1;
	endfunction

	function automatic int peek(int i);
		if (spos + i < sn) return int'(sbuf[spos + i]);
		return sfin ? LOOK_END : LOOK_WAIT;
	endfunction

	function automatic void advance(bit nl);
		if (spos < sn) spos++;
		off++;
		if (nl) begin
			if (cline != 16'hFFFF) cline++;
			ccol = 16'd1;
		end else if (ccol != 16'hFFFF) ccol++;
	endfunction

	function automatic void mark();
		tbeg = off;
		tline = cline;
		tcol = ccol;
	endfunction

	function automatic void emit(logic [6:0] kind, logic [2:0] err);
		tok_t t;
		logic [31:0] n;
		n = off - tbeg;
		lx = LX_IDLE;
		t.kind = kind;
		t.err = err;
		t.offset = tbeg;
		t.len = (n > 32'hFFFF) ? 16'hFFFF : n[15:0];
		t.line = tline;
		t.col = tcol;
		step_toks.push_back(t);
	endfunction

	function automatic bit is_dig(int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alf(int c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == int'(CH_USC);
	endfunction

	function automatic bit base_ok(int c, logic [1:0] b);
		case (b)
			2'd0: return is_dig(c);
			2'd1: return c >= "0" && c <= "7";
			2'd2: return c == "0" || c == "1";
			default: return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		endcase
	endfunction

	function automatic int find_in(string s, int c);
		for (int i = 0; i < s.len(); i++)
			if (int'(s[i]) == c) return i;
		return -1;
	endfunction

	// kinds of one operator family run dbleq, dbl, eq, single
	function automatic void op_kinds(int c, output bit heq, output bit hdbl,
		output bit hdeq, output logic [6:0] ks, output logic [6:0] keq,
		output logic [6:0] kdbl, output logic [6:0] kdeq);
		int idx;
		int k;
		idx = find_in(OP_CHARS, c);
		k = K_OP_BASE;
		for (int j = 0; j < idx; j++)
			k += 1 + (j >= 2) + (j < 2 || j >= 7) + (j >= 11);
		heq = idx >= 2;
		hdbl = idx < 2 || idx >= 7;
		hdeq = idx >= 11;
		kdeq = k[6:0];
		if (hdeq) k++;
		kdbl = k[6:0];
		if (hdbl) k++;
		keq = k[6:0];
		if (heq) k++;
		ks = k[6:0];
	endfunction

	function automatic logic [6:0] word_kind();
		logic [31:0] n;
		bit hit;
		n = off - tbeg;
		if (n == 0 || n > PREFIX_MAX) return K_IDENT;
		for (int i = 0; i < NKW; i++) begin
			hit = KW_LEN[i] == n[3:0];
			for (int j = 0; j < n; j++)
				if (kwp[j] != KW_STR[i][8 * (int'(n) - 1 - j) +: 8]) hit = 1'b0;
			if (hit) return 7'(i);
		end
		return K_IDENT;
	endfunction

	function automatic void open_token(int c);
		int pk;
		pk = find_in(PUNCT_CHARS, c);
		mark();
		advance(1'b0);
		if (pk >= 0) emit(K_PUNCT_BASE + 7'(pk), E_NONE);
		else if (find_in(OP_CHARS, c) >= 0) begin
			quote = c[7:0];
			lx = LX_OP1;
		end else if (c == int'(CH_C)) begin
			kwp[0] = c[7:0];
			lx = LX_CPREFIX;
		end else if (c == int'(CH_DQ) || c == int'(CH_SQ)) begin
			quote = c[7:0];
			lx = LX_STRING;
		end else if (c == int'(CH_ZERO)) lx = LX_ZERO;
		else if (is_dig(c)) begin
			nbase = 2'd0;
			lx = LX_DIGITS;
		end else if (is_alf(c)) begin
			kwp[0] = c[7:0];
			lx = LX_IDENT;
		end else emit(K_ERROR, E_UNEXP);
	endfunction

	function automatic void lex_pump();
		int c0, c1;
		bit heq, hdbl, hdeq;
		logic [6:0] ks, keq, kdbl, kdeq;
		logic [31:0] n;
		forever begin
			c0 = peek(0);
			if (c0 == LOOK_WAIT) return;
			case (lx)
				LX_IDLE: begin
					if (c0 == LOOK_END) begin
						mark();
						emit(K_EOF, E_NONE);
						return;
					end
					if (c0 == int'(CH_SP) || c0 == int'(CH_TAB) || c0 == int'(CH_CR))
						advance(1'b0);
					else if (c0 == int'(CH_NL)) advance(1'b1);
					else if (c0 == int'(CH_SLASH)) begin
						c1 = peek(1);
						if (c1 == LOOK_WAIT) return;
						if (c1 == int'(CH_SLASH)) begin
							advance(1'b0);
							advance(1'b0);
							lx = LX_LINECOM;
						end else if (c1 == int'(CH_STAR)) begin
							advance(1'b0);
							advance(1'b0);
							lx = LX_BLOCK_STAR;
						end else open_token(c0);
					end else open_token(c0);
				end
				LX_LINECOM: begin
					if (c0 == LOOK_END || c0 == int'(CH_NL)) lx = LX_IDLE;
					else advance(1'b0);
				end
				LX_BLOCK, LX_BLOCK_STAR: begin
					if (c0 == LOOK_END) lx = LX_IDLE;
					else if (lx == LX_BLOCK_STAR && c0 == int'(CH_SLASH)) begin
						advance(1'b0);
						lx = LX_IDLE;
					end else begin
						advance(c0 == int'(CH_NL));
						lx = (c0 == int'(CH_STAR)) ? LX_BLOCK_STAR : LX_BLOCK;
					end
				end
				LX_OP1: begin
					op_kinds(quote, heq, hdbl, hdeq, ks, keq, kdbl, kdeq);
					if (hdbl && c0 == int'(quote)) begin
						advance(1'b0);
						if (hdeq) lx = LX_OP2;
						else emit(kdbl, E_NONE);
					end else if (heq && c0 == int'(CH_EQ)) begin
						advance(1'b0);
						emit(keq, E_NONE);
					end else emit(ks, E_NONE);
				end
				LX_OP2: begin
					op_kinds(quote, heq, hdbl, hdeq, ks, keq, kdbl, kdeq);
					if (c0 == int'(CH_EQ)) begin
						advance(1'b0);
						emit(kdeq, E_NONE);
					end else emit(kdbl, E_NONE);
				end
				LX_CPREFIX: begin
					if (c0 == int'(CH_SQ) || c0 == int'(CH_DQ)) begin
						advance(1'b0);
						quote = c0[7:0];
						lx = LX_CHAR_BODY;
					end else lx = LX_IDENT;
				end
				LX_CHAR_BODY: begin
					if (c0 == LOOK_END) emit(K_ERROR, E_BADCHAR);
					else begin
						advance(1'b0);
						lx = LX_CHAR_CLOSE;
					end
				end
				LX_CHAR_CLOSE: begin
					if (c0 == int'(quote)) begin
						advance(1'b0);
						emit(K_CHARLIT, E_NONE);
					end else emit(K_ERROR, E_BADCHAR);
				end
				LX_STRING: begin
					if (c0 == int'(quote)) begin
						advance(1'b0);
						emit(K_STRING, E_NONE);
					end else if (c0 == LOOK_END || c0 == int'(CH_NL)) emit(K_ERROR, E_UNTERM);
					else advance(1'b0);
				end
				LX_ZERO: begin
					if (is_dig(c0) || !is_alf(c0)) begin
						nbase = 2'd0;
						lx = LX_DIGITS;
					end else if (c0 == int'(CH_O) || c0 == int'(CH_B) || c0 == int'(CH_X)) begin
						nbase = (c0 == int'(CH_O)) ? 2'd1 : (c0 == int'(CH_B)) ? 2'd2 : 2'd3;
						advance(1'b0);
						lx = LX_DIGITS;
					end else emit(K_ERROR, E_BASE);
				end
				LX_DIGITS: begin
					if (base_ok(c0, nbase)) advance(1'b0);
					else if (c0 == int'(CH_DOT)) begin
						c1 = peek(1);
						if (c1 == LOOK_WAIT) return;
						if (base_ok(c1, nbase)) begin
							advance(1'b0);
							lx = LX_FRAC;
						end else emit(K_INT_BASE + 7'(nbase), E_NONE);
					end else emit(K_INT_BASE + 7'(nbase), E_NONE);
				end
				LX_FRAC: begin
					if (base_ok(c0, nbase)) advance(1'b0);
					else if (nbase == 2'd0) emit(K_FLOAT, E_NONE);
					else emit(K_ERROR, E_NDFLOAT);
				end
				LX_IDENT: begin
					if (is_alf(c0) || is_dig(c0)) begin
						n = off - tbeg;
						if (n < PREFIX_MAX) kwp[n] = c0[7:0];
						advance(1'b0);
					end else emit(word_kind(), E_NONE);
				end
				default: lx = LX_IDLE;
			endcase
		end
	endfunction

	function automatic void lex_step(logic [7:0] b, logic fin);
		sn = 0;
		foreach (held[i]) sbuf[sn++] = held[i];
		sbuf[sn++] = b;
		spos = 0;
		sfin = fin;
		step_toks.delete();
		lex_pump();
		if (fin) lex_reset();
		else begin
			held.delete();
			for (int i = spos; i < sn && held.size() < 2; i++) held.push_back(sbuf[i]);
		end
		foreach (step_toks[i])
			tok_expect.push_back('{step_toks[i], i == step_toks.size() - 1});
	endfunction

	// stimulus building
	function automatic void put(logic [7:0] c);
		byte_pend.push_back('{c, 1'b0});
	endfunction

	function automatic void put_text(string s, bit fin);
		for (int i = 0; i < s.len(); i++) put(s[i]);
		if (fin) byte_pend[$].last = 1'b1;
	endfunction

	function automatic void put_snippet();
		int i, n;
		logic [7:0] q;
		case ($urandom_range(0, 12))
			0: begin
				i = $urandom_range(0, NKW - 1);
				for (int j = 0; j < KW_LEN[i]; j++) put(KW_STR[i][8 * (KW_LEN[i] - 1 - j) +: 8]);
				if ($urandom_range(0, 3) == 0) put("9");
			end
			1: begin
				n = $urandom_range(1, 12);
				for (int j = 0; j < n; j++)
					case ($urandom_range(0, 4))
						0: put(CH_USC);
						1: put(8'($urandom_range("0", "9")));
						2: put(8'($urandom_range("A", "Z")));
						default: put(8'($urandom_range("a", "z")));
					endcase
			end
			2: begin
				if ($urandom_range(0, 1)) begin
					put(CH_ZERO);
					case ($urandom_range(0, 4))
						0: put(CH_X);
						1: put(CH_O);
						2: put(CH_B);
						3: put(8'($urandom_range("a", "z")));
						default: ;
					endcase
				end
				n = $urandom_range(0, 4);
				for (int j = 0; j < n; j++) put(NUM_CHARS[$urandom_range(0, 16)]);
				if ($urandom_range(0, 2) == 0) begin
					put(CH_DOT);
					n = $urandom_range(0, 3);
					for (int j = 0; j < n; j++) put(FRAC_CHARS[$urandom_range(0, 8)]);
				end
			end
			3: begin
				q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
				put(q);
				n = $urandom_range(0, 6);
				for (int j = 0; j < n; j++) put(8'($urandom_range(32, 126)));
				put($urandom_range(0, 6) == 0 ? CH_NL : q);
			end
			4: begin
				q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
				put(CH_C);
				put(q);
				put(8'($urandom_range(0, 255)));
				put($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255)) : q);
			end
			5: begin
				q = OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)];
				put(q);
				case ($urandom_range(0, 3))
					1: put(q);
					2: put(CH_EQ);
					3: begin put(q); put(CH_EQ); end
					default: ;
				endcase
			end
			6: put(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)]);
			7: begin
				put(CH_SLASH);
				put(CH_SLASH);
				n = $urandom_range(0, 5);
				for (int j = 0; j < n; j++) put(8'($urandom_range(0, 255)));
				put(CH_NL);
			end
			8: begin
				put(CH_SLASH);
				put(CH_STAR);
				n = $urandom_range(0, 6);
				for (int j = 0; j < n; j++) put(CMT_CHARS[$urandom_range(0, 5)]);
				put(CH_STAR);
				put(CH_SLASH);
			end
			9: put(BLANK_CHARS[$urandom_range(0, 3)]);
			10: put(8'($urandom_range(0, 255)));
			default: put(CH_SP);
		endcase
		if ($urandom_range(0, 9) < 7) put(CH_SP);
	endfunction

	// driver
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap = 0;
		end else begin
			go = 1'b0;
			if (src_valid && !src_stall) begin
				lex_step(src_byte, src_last);
				void'(byte_pend.pop_front());
				bytes_in++;
			end
			if (!(src_valid && src_stall)) begin
				if (src_gap > 0) src_gap--;
				else if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(0, 11);
				else go = byte_pend.size() > 0;
				src_valid <= go;
				if (go) begin
					src_byte <= byte_pend[0].ch;
					src_last <= byte_pend[0].last;
				end
			end
		end
	end

	// monitor and stall control
	int  out_gap = 0;
	int  hold_left = 0;
	bit  pressed = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		tok_beat_t e;
		bit st;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (tok_expect.size() == 0) begin
					$error("unexpected token kind %0d at offset %0d", token_kind, start_offset);
					err_count++;
				end else begin
					e = tok_expect.pop_front();
					if (token_kind !== e.t.kind) begin
						$error("token_kind expected %0d actual %0d", e.t.kind, token_kind);
						err_count++;
					end
					if (error_kind !== e.t.err) begin
						$error("error_kind expected %0d actual %0d", e.t.err, error_kind);
						err_count++;
					end
					if (start_offset !== e.t.offset) begin
						$error("start_offset expected %0d actual %0d", e.t.offset, start_offset);
						err_count++;
					end
					if (token_length !== e.t.len) begin
						$error("token_length expected %0d actual %0d", e.t.len, token_length);
						err_count++;
					end
					if (line_number !== e.t.line) begin
						$error("line_number expected %0d actual %0d", e.t.line, line_number);
						err_count++;
					end
					if (column_number !== e.t.col) begin
						$error("column_number expected %0d actual %0d", e.t.col, column_number);
						err_count++;
					end
					if (run_last !== e.last) begin
						$error("run_last expected %0d actual %0d", e.last, run_last);
						err_count++;
					end
				end
			end
			st = 1'b1;
			if (hold_left > 0) hold_left--;
			else if (!pressed && bytes_in >= 150) begin
				pressed = 1'b1;
				hold_left = PRESSURE_CYCLES;
			end else if (out_gap > 0) out_gap--;
			else if (!quiet && $urandom_range(0, 9) == 0) out_gap = $urandom_range(0, 11);
			else st = 1'b0;
			tok_stall <= st;
		end
	end

	// watchdog on progress
	int idle_cycles = 0;
	always @(posedge clk) begin
		in_fire = src_valid && !src_stall;
		out_fire = tok_valid && !tok_stall;
		if (!arst_n || in_fire || out_fire) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int rnd_bytes;
		int n;
		lex_reset();
		put_text("if while uint64 breakall namespace volatile1 ab_9 c cx _Z9", 1'b1);
		put_text("0 0x1F 0b102 0o78 12.5 0x1.f 0b1.1 7. 0q 0.x 9", 1'b1);
		put_text("== = :: : *= * /= / != ! %= % ^= ^ ++ += + -- -= - && &= & ", 1'b0);
		put_text("|| |= | >>= >> >= > <<= << <= <", 1'b1);
		put_text("()[]{},.;?~ @ \"ok\" 'a\n\"open", 1'b1);
		put_text("c'a' c\"\n\" c'ab' c'", 1'b1);
		put_text("a//c\nb/*x\n*/c/*/d/**", 1'b1);
		put_text("/", 1'b1);
		put_text(" ", 1'b1);
		put_text("\t\015\n\377\200x", 1'b1);
		rnd_bytes = 0;
		while (rnd_bytes < 40) begin
			n = byte_pend.size();
			repeat ($urandom_range(3, 12)) put_snippet();
			byte_pend[$].last = 1'b1;
			rnd_bytes += byte_pend.size() - n;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
			if (byte_pend.size() < 60) quiet = 1'b1;
		end while (byte_pend.size() > 0 || tok_expect.size() > 0);
		repeat (40) @(posedge clk);
		if (err_count == 0 && tok_expect.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
